### src/nibble_rle_decoder_macros.svh
// ----------------------------------------------------------------------------
// nibble_rle_decoder_macros
// assertion helpers used by the decoder back end
// ----------------------------------------------------------------------------
`ifndef NIBBLE_RLE_DECODER_MACROS_SVH
`define NIBBLE_RLE_DECODER_MACROS_SVH

// condition holds on every clock edge out of reset
`define NRLE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// antecedent on one edge implies consequent on the next
`define NRLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/nrle_pkg.sv
// ----------------------------------------------------------------------------
// nrle_pkg
// types, constants and the nybble step function of the rle decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nrle_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [3:0] CODE_END    = 4'h0;
    localparam logic [3:0] RAW_BIAS    = 4'd7;
    localparam logic [3:0] RLE_BIAS    = 4'd3;

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_RLE  = 2'd1,
        PH_RAW  = 2'd2
    } t_phase;

    typedef enum logic {
        ST_LOAD = 1'b0,
        ST_EMIT = 1'b1
    } t_bstate;

    typedef struct packed {
        logic [3:0] v;
        logic       is_zero;
        logic       is_short;
    } t_nyb;

    typedef struct packed {
        t_nyb hi;
        t_nyb lo;
    } t_qent;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] raw_left;
        logic [3:0] repeat_count;
        logic [3:0] held;
        logic       half;
    } t_dec;

    typedef struct packed {
        t_dec       nxt;
        logic [2:0] cnt;
        logic [7:0] first;
        logic [7:0] rest;
        logic       is_end;
    } t_step;

    function automatic t_nyb classify(input logic [3:0] v);
        t_nyb n;
        n.v        = v;
        n.is_zero  = (v == CODE_END);
        n.is_short = !v[3] && (v != CODE_END);
        return n;
    endfunction

    function automatic t_step step_nyb(input t_dec s, input t_nyb n);
        t_step      r;
        logic [4:0] tot;
        r.nxt    = s;
        r.cnt    = 3'd0;
        r.first  = {n.v, n.v};
        r.rest   = {n.v, n.v};
        r.is_end = 1'b0;
        tot      = {1'b0, s.repeat_count} + {4'b0, s.half};
        case (s.phase)
            PH_RLE: begin
                r.cnt              = tot[3:1];
                if (s.half) begin
                    r.first = {s.held, n.v};
                end
                r.nxt.half         = tot[0];
                r.nxt.held         = tot[0] ? n.v : 4'd0;
                r.nxt.repeat_count = 4'd0;
                r.nxt.phase        = PH_CODE;
            end
            PH_RAW: begin
                if (s.half) begin
                    r.cnt      = 3'd1;
                    r.first    = {s.held, n.v};
                    r.nxt.half = 1'b0;
                    r.nxt.held = 4'd0;
                end else begin
                    r.nxt.half = 1'b1;
                    r.nxt.held = n.v;
                end
                r.nxt.raw_left = s.raw_left - 4'd1;
                if (s.raw_left == 4'd1) begin
                    r.nxt.phase = PH_CODE;
                end
            end
            default: begin
                if (n.is_zero) begin
                    r.nxt.phase        = PH_CODE;
                    r.nxt.raw_left     = 4'd0;
                    r.nxt.repeat_count = 4'd0;
                    r.nxt.held         = 4'd0;
                    r.nxt.half         = 1'b0;
                    r.is_end           = 1'b1;
                end else if (n.is_short) begin
                    r.nxt.repeat_count = n.v + RLE_BIAS;
                    r.nxt.phase        = PH_RLE;
                end else begin
                    r.nxt.raw_left = n.v - RAW_BIAS;
                    r.nxt.phase    = PH_RAW;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/nibble_rle_decoder.sv
// a pushed byte is queued, planned into the segment registers, then emitted
//   beat by beat into the result slot; all beats of a byte go out before
//   the next byte is popped, at most one beat a cycle while the slot is free
// a 4-deep byte queue lets push run ahead while results drain
// reset: synchronous active low; clears queue, decode state and result slot
// ----------------------------------------------------------------------------
// nibble_rle_decoder
// nybble run-length decoder with queue-style input and result ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nibble_rle_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_packed_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_plain_byte,
    output logic            o_byte_valid,
    output logic            o_stream_end,
    output logic            o_last
);

    logic            q_valid;
    logic            q_pop;
    nrle_pkg::t_qent q_data;

    nrle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_packed_byte (i_packed_byte),
        .i_q_pop       (q_pop),
        .o_q_valid     (q_valid),
        .o_q_data      (q_data)
    );

    nrle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_plain_byte (o_plain_byte),
        .o_byte_valid (o_byte_valid),
        .o_stream_end (o_stream_end),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### src/nrle_front.sv
// ----------------------------------------------------------------------------
// nrle_front
// accepts packed bytes, splits and classifies nybbles, queues them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nrle_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [7:0]        i_packed_byte,
    input  wire logic              i_q_pop,
    output logic                   o_q_valid,
    output nrle_pkg::t_qent        o_q_data
);

    nrle_pkg::t_qent              r_mem [nrle_pkg::QDEPTH];
    logic [nrle_pkg::QAW-1:0]     r_wp, n_wp;
    logic [nrle_pkg::QAW-1:0]     r_rp, n_rp;
    logic [nrle_pkg::QAW:0]       r_cnt, n_cnt;
    logic                         wr;
    logic                         rd;
    nrle_pkg::t_qent              ent;

    assign o_full    = (r_cnt == (nrle_pkg::QAW + 1)'(nrle_pkg::QDEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_mem[r_rp];

    assign wr = i_push && !o_full;
    assign rd = i_q_pop && o_q_valid;

    always_comb begin
        ent.hi = nrle_pkg::classify(i_packed_byte[7:4]);
        ent.lo = nrle_pkg::classify(i_packed_byte[3:0]);
        n_wp   = wr ? r_wp + 1'b1 : r_wp;
        n_rp   = rd ? r_rp + 1'b1 : r_rp;
        n_cnt  = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= ent;
        end
    end

endmodule

`default_nettype wire

### src/nrle_back.sv
// ----------------------------------------------------------------------------
// nrle_back
// decodes per byte and emits one result beat per cycle while the slot is free
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "nibble_rle_decoder_macros.svh"

module nrle_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire nrle_pkg::t_qent   i_q_data,
    output logic                   o_q_pop,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output logic [7:0]             o_plain_byte,
    output logic                   o_byte_valid,
    output logic                   o_stream_end,
    output logic                   o_last
);

    nrle_pkg::t_bstate r_st, n_st;
    nrle_pkg::t_dec    r_dec, n_dec;

    logic [2:0] r_a_cnt, n_a_cnt;
    logic [7:0] r_a_first, n_a_first;
    logic [7:0] r_a_rest, n_a_rest;
    logic       r_a_end, n_a_end;
    logic [2:0] r_b_cnt, n_b_cnt;
    logic [7:0] r_b_first, n_b_first;
    logic [7:0] r_b_rest, n_b_rest;
    logic [2:0] r_total, n_total;
    logic [2:0] r_idx, n_idx;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_bv, n_out_bv;
    logic       r_out_end, n_out_end;
    logic       r_out_last, n_out_last;

    nrle_pkg::t_step s1;
    nrle_pkg::t_step s2;
    logic            slot_free;
    logic            emit;
    logic [2:0]      j;
    logic [7:0]      sel_byte;
    logic            sel_bv;
    logic            sel_last;

    assign o_empty      = !r_out_valid;
    assign o_plain_byte = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_stream_end = r_out_end;
    assign o_last       = r_out_last;

    assign slot_free = !r_out_valid || i_pop;
    assign emit      = (r_st == nrle_pkg::ST_EMIT) && slot_free;
    assign o_q_pop   = (r_st == nrle_pkg::ST_LOAD) && i_q_valid;

    // plan for one byte: segment a from the high nybble, b from the low one
    always_comb begin
        s1 = nrle_pkg::step_nyb(r_dec, i_q_data.hi);
        s2 = nrle_pkg::step_nyb(s1.nxt, i_q_data.lo);
    end

    // pick the result at the current index
    always_comb begin
        j        = r_idx - r_a_cnt;
        sel_last = (r_idx == r_total - 3'd1);
        if (r_idx < r_a_cnt) begin
            sel_byte = (r_idx == 3'd0) ? r_a_first : r_a_rest;
            sel_bv   = 1'b1;
        end else if (!r_a_end && (j < r_b_cnt)) begin
            sel_byte = (j == 3'd0) ? r_b_first : r_b_rest;
            sel_bv   = 1'b1;
        end else begin
            sel_byte = 8'h00;
            sel_bv   = 1'b0;
        end
    end

    always_comb begin
        n_st        = r_st;
        n_dec       = r_dec;
        n_a_cnt     = r_a_cnt;
        n_a_first   = r_a_first;
        n_a_rest    = r_a_rest;
        n_a_end     = r_a_end;
        n_b_cnt     = r_b_cnt;
        n_b_first   = r_b_first;
        n_b_rest    = r_b_rest;
        n_total     = r_total;
        n_idx       = r_idx;
        n_out_valid = i_pop ? 1'b0 : r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_bv    = r_out_bv;
        n_out_end   = r_out_end;
        n_out_last  = r_out_last;
        case (r_st)
            nrle_pkg::ST_LOAD: begin
                if (i_q_valid) begin
                    n_dec     = s1.is_end ? s1.nxt : s2.nxt;
                    n_a_cnt   = s1.cnt;
                    n_a_first = s1.first;
                    n_a_rest  = s1.rest;
                    n_a_end   = s1.is_end;
                    n_b_cnt   = s1.is_end ? 3'd0 : s2.cnt;
                    n_b_first = s2.first;
                    n_b_rest  = s2.rest;
                    n_total   = s1.cnt + {2'b0, s1.is_end}
                              + (s1.is_end ? 3'd0 : s2.cnt + {2'b0, s2.is_end});
                    n_idx     = 3'd0;
                    if (n_total != 3'd0) begin
                        n_st = nrle_pkg::ST_EMIT;
                    end
                end
            end
            nrle_pkg::ST_EMIT: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = sel_byte;
                    n_out_bv    = sel_bv;
                    n_out_end   = !sel_bv;
                    n_out_last  = sel_last;
                    n_idx       = r_idx + 3'd1;
                    if (sel_last) begin
                        n_st = nrle_pkg::ST_LOAD;
                    end
                end
            end
            default: begin
                n_st = nrle_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st             <= nrle_pkg::ST_LOAD;
            r_dec.phase      <= nrle_pkg::PH_CODE;
            r_dec.raw_left   <= 4'd0;
            r_dec.repeat_count <= 4'd0;
            r_dec.held       <= 4'd0;
            r_dec.half       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_idx            <= 3'd0;
            r_total          <= 3'd0;
        end else begin
            r_st        <= n_st;
            r_dec       <= n_dec;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_total     <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_cnt    <= n_a_cnt;
        r_a_first  <= n_a_first;
        r_a_rest   <= n_a_rest;
        r_a_end    <= n_a_end;
        r_b_cnt    <= n_b_cnt;
        r_b_first  <= n_b_first;
        r_b_rest   <= n_b_rest;
        r_out_byte <= n_out_byte;
        r_out_bv   <= n_out_bv;
        r_out_end  <= n_out_end;
        r_out_last <= n_out_last;
    end

    `NRLE_ASSERT_ALWAYS(a_idx_range, (r_st != nrle_pkg::ST_EMIT) || (r_idx < r_total),
        "emit index past planned result count")
    `NRLE_ASSERT_ALWAYS(a_end_excl, !(r_out_valid && r_out_bv && r_out_end),
        "result flagged both byte and stream end")
    `NRLE_ASSERT_NEXT(a_last_done, emit && sel_last, r_st == nrle_pkg::ST_LOAD,
        "last beat did not return to load")

endmodule

`default_nettype wire
